[rtl/core/fas_pkg.sv]
// shared types and constants of the frame animation sequencer
package fas_pkg;

	localparam int ADDR_BITS = 4;
	localparam int DATA_BITS = 32;

	// table geometry
	localparam int NUM_SEQUENCES = 16;
	localparam int SEQ_SLOTS     = 32;
	localparam int FRAME_BITS    = 8;
	localparam int TBL_DEPTH     = NUM_SEQUENCES * SEQ_SLOTS;
	localparam int TBL_ADDR_W    = $clog2(TBL_DEPTH);

	// register addresses
	localparam logic [1:0] REG_MODE     = 2'd0;
	localparam logic [1:0] REG_ONE_SHOT = 2'd1;
	localparam logic [1:0] REG_SPEED    = 2'd2;
	localparam logic [1:0] REG_NFRAMES  = 2'd3;

	// opcodes
	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_WRITE  = 3'd1;
	localparam logic [2:0] OP_SELECT = 3'd2;
	localparam logic [2:0] OP_STEP   = 3'd3;
	localparam logic [2:0] OP_FRAME  = 3'd4;

	// status codes
	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_WRAP = 2'd2;

	typedef enum logic [1:0] {
		MODE_SINGLE = 2'd0,
		MODE_COUNT  = 2'd1,
		MODE_TABLE  = 2'd2,
		MODE_NONE   = 2'd3
	} fas_mode_t;

	typedef struct packed {
		fas_mode_t   mode;
		logic        one_shot;
		logic [15:0] speed;
		logic [8:0]  nframes;
	} fas_cfg_t;

endpackage

[rtl/core/fas_regs.sv]
// configuration registers behind the apb port
module fas_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [fas_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [fas_pkg::DATA_BITS-1:0]    pwdata,
	output logic [fas_pkg::DATA_BITS-1:0]    prdata,
	output logic                             pready,
	output fas_pkg::fas_cfg_t                cfg
);
	import fas_pkg::*;

	fas_cfg_t cfg_q;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= MODE_SINGLE;
			cfg_q.one_shot <= 1'b0;
			cfg_q.speed    <= 16'd1;
			cfg_q.nframes  <= 9'd0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_MODE:     cfg_q.mode     <= fas_mode_t'(pwdata[1:0]);
				REG_ONE_SHOT: cfg_q.one_shot <= pwdata[0];
				REG_SPEED:    cfg_q.speed    <= pwdata[15:0];
				REG_NFRAMES:  cfg_q.nframes  <= pwdata[8:0];
				default:      cfg_q.mode     <= cfg_q.mode;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MODE:     prdata = DATA_BITS'(cfg_q.mode);
			REG_ONE_SHOT: prdata = DATA_BITS'(cfg_q.one_shot);
			REG_SPEED:    prdata = DATA_BITS'(cfg_q.speed);
			REG_NFRAMES:  prdata = DATA_BITS'(cfg_q.nframes);
			default:      prdata = '0;
		endcase
	end

endmodule

[rtl/core/fas_table.sv]
// sequence table memory, one write port and two registered read ports
module fas_table #(
	parameter int DEPTH  = 512,
	parameter int WIDTH  = 9,
	parameter int ADDR_W = 9
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr_a,
	input  logic [ADDR_W-1:0] rd_addr_b,
	output logic [WIDTH-1:0]  rd_data_a,
	output logic [WIDTH-1:0]  rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

[rtl/core/fas_ctrl.sv]
// sequencer state, table addressing, read-modify-write stage and output register
module fas_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fas_pkg::fas_cfg_t                 cfg,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        opcode,
	input  logic [3:0]                        seq_select,
	input  logic [4:0]                        position,
	input  logic [7:0]                        frame_value,
	input  logic                              end_mark,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        frame,
	output logic [1:0]                        status,
	output logic [4:0]                        step_index,
	output logic                              tbl_wr_en,
	output logic [fas_pkg::TBL_ADDR_W-1:0]    tbl_wr_addr,
	output logic [fas_pkg::FRAME_BITS:0]      tbl_wr_data,
	output logic                              tbl_rd_en,
	output logic [fas_pkg::TBL_ADDR_W-1:0]    tbl_rd_addr_a,
	output logic [fas_pkg::TBL_ADDR_W-1:0]    tbl_rd_addr_b,
	input  logic [fas_pkg::FRAME_BITS:0]      tbl_rd_data_a,
	input  logic [fas_pkg::FRAME_BITS:0]      tbl_rd_data_b
);
	import fas_pkg::*;

	localparam int ADDR_W    = TBL_ADDR_W;
	localparam int SEQ_W     = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
	localparam int SLOT_W    = $clog2(SEQ_SLOTS);
	localparam int NXT_W     = SLOT_W + 1;
	localparam int CMP_W     = (FRAME_BITS + 1 > 9) ? FRAME_BITS + 1 : 9;
	localparam int FRAME_MAX = (1 << FRAME_BITS) - 1;

	// architectural state
	logic [FRAME_BITS-1:0] frame_q;
	logic [SLOT_W-1:0]     step_q;
	logic [15:0]           tick_q;
	logic [1:0]            status_q;
	logic [SEQ_W-1:0]      seq_q;

	// stage 1 word
	logic                  valid_s1;
	logic [2:0]            op_s1;
	logic [3:0]            sel_s1;
	logic [4:0]            pos_s1;
	logic [7:0]            fv_s1;

	// output register
	logic                  out_valid_q;
	logic [7:0]            frame_q2;
	logic [1:0]            status_q2;
	logic [4:0]            step_index_q;

	logic                  in_acc;
	logic                  adv_s1;
	logic                  ptr_busy;
	logic                  ptr_need;
	logic [ADDR_W-1:0]     base_act;
	logic [ADDR_W-1:0]     base_in;
	logic [NXT_W-1:0]      step_inc;
	logic                  in_seq_ok;
	logic                  in_pos_ok;

	logic [FRAME_BITS-1:0] frame_n;
	logic [SLOT_W-1:0]     step_n;
	logic [15:0]           tick_n;
	logic [1:0]            status_n;
	logic [SEQ_W-1:0]      seq_n;
	logic [NXT_W-1:0]      nxt_s1;
	logic [16:0]           tick_sum;
	logic [15:0]           limit;
	logic [FRAME_BITS:0]   fcount;

	// ---------------- input side and table addressing ----------------

	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign ptr_busy = valid_s1 && ((op_s1 == OP_TICK && cfg.mode == MODE_TABLE) ||
		op_s1 == OP_SELECT || op_s1 == OP_STEP);
	assign ptr_need = (opcode == OP_TICK && cfg.mode == MODE_TABLE) || opcode == OP_STEP;
	assign in_stall = (valid_s1 && !adv_s1) || (ptr_busy && ptr_need);
	assign in_acc   = in_valid && !in_stall;

	assign in_seq_ok = 9'(seq_select) < 9'(NUM_SEQUENCES);
	assign in_pos_ok = 9'(position) < 9'(SEQ_SLOTS);
	assign base_act  = ADDR_W'(seq_q) * ADDR_W'(SEQ_SLOTS);
	assign base_in   = ADDR_W'(seq_select) * ADDR_W'(SEQ_SLOTS);
	assign step_inc  = NXT_W'(step_q) + NXT_W'(1);

	assign tbl_wr_en   = in_acc && opcode == OP_WRITE && in_seq_ok && in_pos_ok;
	assign tbl_wr_addr = base_in + ADDR_W'(position);
	assign tbl_wr_data = {end_mark, FRAME_BITS'(frame_value)};
	assign tbl_rd_en   = in_acc;

	always_comb begin
		case (opcode)
			OP_SELECT: tbl_rd_addr_a = base_in;
			OP_STEP:   tbl_rd_addr_a = base_act + ADDR_W'(position);
			default:   tbl_rd_addr_a = base_act + ADDR_W'(step_inc);
		endcase
		tbl_rd_addr_b = cfg.one_shot ? base_act + ADDR_W'(step_q) : base_act;
	end

	// ---------------- stage 1: modify ----------------

	always_comb begin
		frame_n  = frame_q;
		step_n   = step_q;
		tick_n   = tick_q;
		status_n = status_q;
		seq_n    = seq_q;
		nxt_s1   = NXT_W'(step_q) + NXT_W'(1);
		limit    = (cfg.speed == 16'd0) ? 16'd1 : cfg.speed;
		tick_sum = 17'(tick_q) + 17'(1);
		fcount   = (FRAME_BITS + 1)'(frame_q) + (FRAME_BITS + 1)'(1);
		case (op_s1)
			OP_TICK: begin
				status_n = ST_RUN;
				case (cfg.mode)
					MODE_SINGLE: begin
						frame_n  = '0;
						status_n = ST_DONE;
					end
					MODE_COUNT, MODE_TABLE: begin
						if (tick_sum < 17'(limit)) begin
							tick_n = tick_sum[15:0];
						end else begin
							tick_n = '0;
							if (cfg.mode == MODE_COUNT) begin
								if (CMP_W'(fcount) >= CMP_W'(cfg.nframes) ||
									fcount[FRAME_BITS]) begin
									frame_n  = '0;
									status_n = ST_WRAP;
								end else begin
									frame_n = fcount[FRAME_BITS-1:0];
								end
							end else if (nxt_s1 < NXT_W'(SEQ_SLOTS) &&
								!tbl_rd_data_a[FRAME_BITS]) begin
								step_n  = nxt_s1[SLOT_W-1:0];
								frame_n = tbl_rd_data_a[FRAME_BITS-1:0];
							end else if (cfg.one_shot) begin
								status_n = ST_DONE;
								frame_n  = tbl_rd_data_b[FRAME_BITS-1:0];
							end else begin
								status_n = ST_WRAP;
								step_n   = '0;
								frame_n  = tbl_rd_data_b[FRAME_BITS-1:0];
							end
						end
					end
					default: status_n = ST_RUN;
				endcase
			end
			OP_SELECT: begin
				if (9'(sel_s1) < 9'(NUM_SEQUENCES)) begin
					seq_n  = SEQ_W'(sel_s1);
					step_n = '0;
					if (cfg.mode == MODE_TABLE) begin
						frame_n = tbl_rd_data_a[FRAME_BITS-1:0];
					end
				end
			end
			OP_STEP: begin
				if ((cfg.mode == MODE_TABLE || cfg.one_shot) &&
					9'(pos_s1) < 9'(SEQ_SLOTS)) begin
					step_n  = SLOT_W'(pos_s1);
					frame_n = tbl_rd_data_a[FRAME_BITS-1:0];
				end
			end
			OP_FRAME: begin
				if (CMP_W'(fv_s1) < CMP_W'(cfg.nframes) && 17'(fv_s1) <= 17'(FRAME_MAX)) begin
					frame_n = FRAME_BITS'(fv_s1);
				end
			end
			default: frame_n = frame_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q     <= '0;
			step_q      <= '0;
			tick_q      <= '0;
			status_q    <= ST_DONE;
			seq_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				frame_q     <= frame_n;
				step_q      <= step_n;
				tick_q      <= tick_n;
				status_q    <= status_n;
				seq_q       <= seq_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1  <= opcode;
			sel_s1 <= seq_select;
			pos_s1 <= position;
			fv_s1  <= frame_value;
		end
		if (adv_s1) begin
			frame_q2     <= 8'(frame_n);
			status_q2    <= status_n;
			step_index_q <= 5'(step_n);
		end
	end

	assign out_valid  = out_valid_q;
	assign frame      = frame_q2;
	assign status     = status_q2;
	assign step_index = step_index_q;

endmodule

[rtl/core/frame_animation_sequencer.sv]
// top level of the sprite frame animation sequencer
// Takes one word per clock while in_stall is low and returns one result word per input word:
// the sequence table is read into registered read ports as the word is accepted, stage 1
// updates the state from that read data, and the result goes to the output register. A tick
// in table mode or a set-step word that directly follows a tick in table mode, a sequence
// select or a set-step word stalls until the earlier word leaves stage 1, since its table
// addresses depend on the step pointer or sequence still being updated. Table writes and all
// other words run at one per cycle unless the output stalls. The table comes out of reset
// unwritten and needs no clearing pass; entries must be written before a sequence that uses
// them is played. The user must write configuration over the apb port while the block is idle.
module frame_animation_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fas_pkg::ADDR_BITS-1:0] paddr,
	input  logic [fas_pkg::DATA_BITS-1:0] pwdata,
	output logic [fas_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    opcode,
	input  logic [3:0]                    seq_select,
	input  logic [4:0]                    position,
	input  logic [7:0]                    frame_value,
	input  logic                          end_mark,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    frame,
	output logic [1:0]                    status,
	output logic [4:0]                    step_index
);
	import fas_pkg::*;

	localparam int DEPTH  = TBL_DEPTH;
	localparam int ADDR_W = TBL_ADDR_W;

	fas_cfg_t              cfg;
	logic                  tbl_wr_en;
	logic [ADDR_W-1:0]     tbl_wr_addr;
	logic [FRAME_BITS:0]   tbl_wr_data;
	logic                  tbl_rd_en;
	logic [ADDR_W-1:0]     tbl_rd_addr_a;
	logic [ADDR_W-1:0]     tbl_rd_addr_b;
	logic [FRAME_BITS:0]   tbl_rd_data_a;
	logic [FRAME_BITS:0]   tbl_rd_data_b;

	fas_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fas_table #(
		.DEPTH  (DEPTH),
		.WIDTH  (FRAME_BITS + 1),
		.ADDR_W (ADDR_W)
	) u_table (
		.clk       (clk),
		.wr_en     (tbl_wr_en),
		.wr_addr   (tbl_wr_addr),
		.wr_data   (tbl_wr_data),
		.rd_en     (tbl_rd_en),
		.rd_addr_a (tbl_rd_addr_a),
		.rd_addr_b (tbl_rd_addr_b),
		.rd_data_a (tbl_rd_data_a),
		.rd_data_b (tbl_rd_data_b)
	);

	fas_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.seq_select    (seq_select),
		.position      (position),
		.frame_value   (frame_value),
		.end_mark      (end_mark),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame         (frame),
		.status        (status),
		.step_index    (step_index),
		.tbl_wr_en     (tbl_wr_en),
		.tbl_wr_addr   (tbl_wr_addr),
		.tbl_wr_data   (tbl_wr_data),
		.tbl_rd_en     (tbl_rd_en),
		.tbl_rd_addr_a (tbl_rd_addr_a),
		.tbl_rd_addr_b (tbl_rd_addr_b),
		.tbl_rd_data_a (tbl_rd_data_a),
		.tbl_rd_data_b (tbl_rd_data_b)
	);

endmodule
